// ----- rtl/pcarl_pkg.sv -----
// ============================================================================
// pcarl_pkg: shared definitions for the per-channel alert rate limiter
// Types, register indexes and constants used by the limiter and its checker.
// ============================================================================
package pcarl_pkg;

  // Number of reason codes that own a counter; higher codes are not counted.
  localparam int unsigned REASONS        = 6;
  localparam int unsigned REASON_IDX_W   = (REASONS > 1) ? $clog2(REASONS) : 1;
  // Time after the last accepted alert during which the block reports activity.
  localparam int unsigned ANNOUNCE_WINDOW = 2500;

  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned REPEAT_W   = 8;
  localparam int unsigned COOL_W     = 16;
  localparam int unsigned QUIET_W    = 20;
  localparam int unsigned CAPS_W     = 24;
  localparam int unsigned REASON_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Channel numbers.
  localparam logic [CHAN_W-1:0] CHAN_DROWSY   = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_SNEEZE   = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_PRESENCE = 2'd2;

  // Reason codes with a channel of their own.
  localparam logic [REASON_W-1:0] REASON_SNEEZE    = 3'd4;
  localparam logic [REASON_W-1:0] REASON_NO_DRIVER = 3'd5;

  typedef enum logic {
    OP_TRIGGER = 1'b0,
    OP_QUERY   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE         = 3'd0,
    CFG_COOL_DROWSY    = 3'd1,
    CFG_COOL_SNEEZE    = 3'd2,
    CFG_COOL_PRESENCE  = 3'd3,
    CFG_QUIET_DROWSY   = 3'd4,
    CFG_QUIET_SNEEZE   = 3'd5,
    CFG_QUIET_PRESENCE = 3'd6,
    CFG_REPEAT_CAPS    = 3'd7
  } cfg_reg_e;

  // Channel that a reason code is routed to.
  function automatic logic [CHAN_W-1:0] chan_of(input logic [REASON_W-1:0] reason);
    logic [CHAN_W-1:0] ch;
    ch = CHAN_DROWSY;
    if (reason == REASON_SNEEZE) begin
      ch = CHAN_SNEEZE;
    end else if (reason == REASON_NO_DRIVER) begin
      ch = CHAN_PRESENCE;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/per_channel_alert_rate_limiter.sv -----
// ============================================================================
// per_channel_alert_rate_limiter: rate limiting of timestamped alert requests
// Routes each alert to one of three channels, applies cooldown, quiet-span
// episode reset and repeat cap, and keeps total and per-reason counters.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request: an operation
//   (trigger or status query), the current time in ms and a reason code.
//   Output channel (out_valid_o / out_ready_i) carries one result per request:
//   accept flag, channel, episode-cleared flag, total and per-reason counts
//   and the announcing flag.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes one register per
//   request; it is always ready and should only be used while the block idles.
//   Throughput: one request per cycle while the receiver does not stall; the
//   input register and the result register form a two-stage pipe, and all
//   channel state is read, and on a trigger updated, in the same cycle a
//   request moves from the input to the result register.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_ready_o drops until the result is taken.
//   Reset clears all counters, channel state and configuration registers; the
//   block is disabled after reset and refuses every trigger until enabled.
// ============================================================================
module per_channel_alert_rate_limiter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pcarl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcarl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Request channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic [pcarl_pkg::TIME_W-1:0]          now_time_i,
  input  logic [pcarl_pkg::REASON_W-1:0]        reason_code_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  accepted_o,
  output logic [pcarl_pkg::CHAN_W-1:0]          channel_id_o,
  output logic                                  episode_cleared_o,
  output logic [pcarl_pkg::COUNT_W-1:0]         total_alerts_o,
  output logic [pcarl_pkg::COUNT_W-1:0]         reason_alerts_o,
  output logic                                  announcing_o
);

  localparam int unsigned NumChan  = pcarl_pkg::NUM_CHAN;
  localparam int unsigned Reasons  = pcarl_pkg::REASONS;
  localparam int unsigned TimeW    = pcarl_pkg::TIME_W;
  localparam int unsigned CountW   = pcarl_pkg::COUNT_W;
  localparam int unsigned RepeatW  = pcarl_pkg::REPEAT_W;
  localparam logic [RepeatW-1:0] RepeatMax = {RepeatW{1'b1}};

  // Configuration registers.
  logic                               enable_q;
  logic [pcarl_pkg::COOL_W-1:0]       cool_q  [NumChan];
  logic [pcarl_pkg::QUIET_W-1:0]      quiet_q [NumChan];
  logic [pcarl_pkg::CAPS_W-1:0]       caps_q;

  // Channel and counter state.
  logic [TimeW-1:0]                   last_accept_q  [NumChan];
  logic [RepeatW-1:0]                 repeat_q       [NumChan];
  logic [CountW-1:0]                  total_q;
  logic [CountW-1:0]                  reason_cnt_q   [Reasons];
  logic [TimeW-1:0]                   last_any_q;

  // Input register.
  logic                               in_vld_q;
  logic                               op_q;
  logic [TimeW-1:0]                   now_q;
  logic [pcarl_pkg::REASON_W-1:0]     reason_q;

  // Result register.
  logic                               out_vld_q;
  logic                               acc_q;
  logic [pcarl_pkg::CHAN_W-1:0]       chan_q;
  logic                               clr_q;
  logic [CountW-1:0]                  total_res_q;
  logic [CountW-1:0]                  reason_res_q;
  logic                               ann_q;

  // Datapath signals.
  logic                               advance;
  logic [pcarl_pkg::CHAN_W-1:0]       ch;
  logic [TimeW-1:0]                   since;
  logic [RepeatW-1:0]                 rep_cur;
  logic [RepeatW-1:0]                 rep_eff;
  logic [RepeatW-1:0]                 rep_d;
  logic [RepeatW-1:0]                 cap;
  logic                               trig;
  logic                               quiet_hit;
  logic                               refuse;
  logic                               acc;
  logic                               counted;
  logic [pcarl_pkg::REASON_IDX_W-1:0] ridx;
  logic [CountW-1:0]                  rsn_cur;
  logic [CountW-1:0]                  rsn_d;
  logic [CountW-1:0]                  total_d;
  logic [TimeW-1:0]                   last_any_d;
  logic [TimeW-1:0]                   ann_gap;

  assign cfg_ready_o = 1'b1;

  // Pipe control: the input register empties whenever the result register can take it.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Channel lookup and episode / cooldown / cap decisions.
  always_comb begin
    ch        = pcarl_pkg::chan_of(reason_q);
    since     = now_q - last_accept_q[ch];
    rep_cur   = repeat_q[ch];
    cap       = caps_q[RepeatW*ch +: RepeatW];
    trig      = (pcarl_pkg::op_e'(op_q) == pcarl_pkg::OP_TRIGGER) && enable_q;
    quiet_hit = (rep_cur != '0) && (quiet_q[ch] != '0) &&
                (since >= TimeW'(quiet_q[ch]));
    rep_eff   = quiet_hit ? '0 : rep_cur;
    refuse    = ((rep_eff != '0) && (since < TimeW'(cool_q[ch]))) ||
                ((cap != '0) && (rep_eff >= cap));
    acc       = trig && !refuse;
    rep_d     = (acc && (rep_eff != RepeatMax)) ? rep_eff + RepeatW'(1) : rep_eff;
  end

  // Counter updates and announcing window.
  always_comb begin
    counted    = {1'b0, reason_q} < (pcarl_pkg::REASON_W + 1)'(Reasons);
    ridx       = reason_q[pcarl_pkg::REASON_IDX_W-1:0];
    rsn_cur    = counted ? reason_cnt_q[ridx] : '0;
    rsn_d      = rsn_cur + CountW'(acc && counted);
    total_d    = total_q + CountW'(acc);
    last_any_d = acc ? now_q : last_any_q;
    ann_gap    = now_q - last_any_d;
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      caps_q   <= '0;
      for (int i = 0; i < NumChan; i++) begin
        cool_q[i]  <= '0;
        quiet_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (pcarl_pkg::cfg_reg_e'(cfg_index_i))
        pcarl_pkg::CFG_ENABLE:         enable_q   <= cfg_data_i[0];
        pcarl_pkg::CFG_COOL_DROWSY:    cool_q[0]  <= cfg_data_i[pcarl_pkg::COOL_W-1:0];
        pcarl_pkg::CFG_COOL_SNEEZE:    cool_q[1]  <= cfg_data_i[pcarl_pkg::COOL_W-1:0];
        pcarl_pkg::CFG_COOL_PRESENCE:  cool_q[2]  <= cfg_data_i[pcarl_pkg::COOL_W-1:0];
        pcarl_pkg::CFG_QUIET_DROWSY:   quiet_q[0] <= cfg_data_i[pcarl_pkg::QUIET_W-1:0];
        pcarl_pkg::CFG_QUIET_SNEEZE:   quiet_q[1] <= cfg_data_i[pcarl_pkg::QUIET_W-1:0];
        pcarl_pkg::CFG_QUIET_PRESENCE: quiet_q[2] <= cfg_data_i[pcarl_pkg::QUIET_W-1:0];
        pcarl_pkg::CFG_REPEAT_CAPS:    caps_q     <= cfg_data_i[pcarl_pkg::CAPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel and counter state, updated as a request passes to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      last_any_q <= '0;
      for (int i = 0; i < NumChan; i++) begin
        last_accept_q[i] <= '0;
        repeat_q[i]      <= '0;
      end
      for (int r = 0; r < Reasons; r++) begin
        reason_cnt_q[r] <= '0;
      end
    end else if (advance && trig) begin
      repeat_q[ch] <= rep_d;
      if (acc) begin
        last_accept_q[ch] <= now_q;
        last_any_q        <= now_q;
        total_q           <= total_d;
        if (counted) begin
          reason_cnt_q[ridx] <= rsn_d;
        end
      end
    end
  end

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= operation_i;
      now_q    <= now_time_i;
      reason_q <= reason_code_i;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      acc_q        <= acc;
      chan_q       <= ch;
      clr_q        <= trig && quiet_hit;
      total_res_q  <= total_d;
      reason_res_q <= counted ? rsn_d : '0;
      ann_q        <= (total_d != '0) &&
                      (ann_gap < TimeW'(pcarl_pkg::ANNOUNCE_WINDOW));
    end
  end

  assign out_valid_o       = out_vld_q;
  assign accepted_o        = acc_q;
  assign channel_id_o      = chan_q;
  assign episode_cleared_o = clr_q;
  assign total_alerts_o    = total_res_q;
  assign reason_alerts_o   = reason_res_q;
  assign announcing_o      = ann_q;

endmodule

// ----- rtl/pcarl_checker.sv -----
// ============================================================================
// pcarl_checker: port-level checks for the alert rate limiter
// Watches the result channel and the running total across delivered results.
// ============================================================================
module pcarl_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              accepted_o,
  input logic [pcarl_pkg::CHAN_W-1:0]      channel_id_o,
  input logic [pcarl_pkg::COUNT_W-1:0]     total_alerts_o
);

  logic [pcarl_pkg::COUNT_W-1:0] last_total_q;

  // Total reported with the most recently delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_total_q <= total_alerts_o;
    end
  end

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(total_alerts_o) && $stable(accepted_o)
                                    && $stable(channel_id_o))
    else $error("result payload changed while stalled");

  // Only three channels exist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_id_o != 2'd3)
    else $error("channel out of range");

  // The total grows by one exactly for an accepted alert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o ? (total_alerts_o == last_total_q + 32'd1)
                                : (total_alerts_o == last_total_q)))
    else $error("total count does not follow accepted alerts");

endmodule

bind per_channel_alert_rate_limiter pcarl_checker u_pcarl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .channel_id_o   (channel_id_o),
  .total_alerts_o (total_alerts_o)
);
